>>> rtl/cpu8alu_pkg.sv
// Shared types and constants for the 8-bit ALU with Z/N/H/C flags.
// Used by cpu8alu_core and cpu8_alu_with_flags_top; depends on nothing.

package cpu8alu_pkg;

   localparam int unsigned OPCODE_W   = 5;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BIT_IDX_W  = 3;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [7:0] BCD_BYTE_MAX = 8'h99;
   localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_XOR   = 5'd5,
      OP_OR    = 5'd6,
      OP_CP    = 5'd7,
      OP_INC   = 5'd8,
      OP_DEC   = 5'd9,
      OP_ADD16 = 5'd10,
      OP_RLC   = 5'd11,
      OP_RRC   = 5'd12,
      OP_RL    = 5'd13,
      OP_RR    = 5'd14,
      OP_SLA   = 5'd15,
      OP_SRA   = 5'd16,
      OP_SRL   = 5'd17,
      OP_BIT   = 5'd18,
      OP_SET   = 5'd19,
      OP_RES   = 5'd20,
      OP_DAA   = 5'd21
   } opcode_type;

   typedef struct packed {
      logic zero;
      logic subtract;
      logic half_carry;
      logic carry;
   } flags_type;

endpackage

>>> rtl/cpu8alu_core.sv
// Combinational ALU datapath: one operation, result and new flags.
// Depends on cpu8alu_pkg for the opcode codes and the flag struct.

module cpu8alu_core
   import cpu8alu_pkg::*;
(
   input  logic [OPCODE_W-1:0]  opcode,
   input  logic [WORD_W-1:0]    operand_a,
   input  logic [WORD_W-1:0]    operand_b,
   input  logic [BIT_IDX_W-1:0] bit_index,
   input  flags_type            flags_in,
   output logic [WORD_W-1:0]    result,
   output flags_type            flags_out
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        add_cin;
   logic        sub_cin;
   logic [8:0]  sum8;
   logic [4:0]  sum_nib;
   logic [8:0]  diff8;
   logic [4:0]  diff_nib;
   logic [16:0] sum16;
   logic [12:0] sum12;
   logic [7:0]  bit_mask;
   logic        daa_lo;
   logic        daa_hi;
   logic [7:0]  daa_add;
   logic [7:0]  daa_sub;
   logic        set_zero;

   assign a = operand_a[BYTE_W-1:0];
   assign b = operand_b[BYTE_W-1:0];

   assign add_cin = (opcode == OP_ADC) ? flags_in.carry : 1'b0;
   assign sub_cin = (opcode == OP_SBC) ? flags_in.carry : 1'b0;

   assign sum8    = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
   assign sum_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
   // bit 8 / bit 4 of the difference is the borrow
   assign diff8    = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
   assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};

   assign sum16 = {1'b0, operand_a} + {1'b0, operand_b};
   assign sum12 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

   assign bit_mask = 8'd1 << bit_index;

   // decimal adjust: both tests look at the original accumulator
   assign daa_lo  = flags_in.half_carry || (a[3:0] > BCD_DIGIT_MAX);
   assign daa_hi  = flags_in.carry || (a > BCD_BYTE_MAX);
   assign daa_add = (daa_lo ? DAA_LOW_ADJ : 8'd0) | (daa_hi ? DAA_HIGH_ADJ : 8'd0);
   assign daa_sub = (flags_in.half_carry ? DAA_LOW_ADJ : 8'd0)
                  | (flags_in.carry ? DAA_HIGH_ADJ : 8'd0);

   always_comb begin
      result    = operand_a;
      flags_out = flags_in;
      set_zero  = 1'b1;
      case (opcode)
         OP_ADD, OP_ADC: begin
            result               = {8'd0, sum8[7:0]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = sum_nib[4];
            flags_out.carry      = sum8[8];
         end
         OP_SUB, OP_SBC: begin
            result               = {8'd0, diff8[7:0]};
            flags_out.subtract   = 1'b1;
            flags_out.half_carry = diff_nib[4];
            flags_out.carry      = diff8[8];
         end
         OP_CP: begin
            result               = {8'd0, a};
            flags_out.zero       = (a == b);
            flags_out.subtract   = 1'b1;
            flags_out.half_carry = diff_nib[4];
            flags_out.carry      = diff8[8];
            set_zero             = 1'b0;
         end
         OP_AND: begin
            result               = {8'd0, a & b};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b1;
            flags_out.carry      = 1'b0;
         end
         OP_XOR: begin
            result               = {8'd0, a ^ b};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = 1'b0;
         end
         OP_OR: begin
            result               = {8'd0, a | b};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = 1'b0;
         end
         OP_INC: begin
            result               = {8'd0, a + 8'd1};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = (a[3:0] == 4'hF);
         end
         OP_DEC: begin
            result               = {8'd0, a - 8'd1};
            flags_out.subtract   = 1'b1;
            flags_out.half_carry = (a[3:0] == 4'h0);
         end
         OP_ADD16: begin
            result               = sum16[15:0];
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = sum12[12];
            flags_out.carry      = sum16[16];
            set_zero             = 1'b0;
         end
         OP_RLC: begin
            result               = {8'd0, a[6:0], a[7]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[7];
         end
         OP_RRC: begin
            result               = {8'd0, a[0], a[7:1]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[0];
         end
         OP_RL: begin
            result               = {8'd0, a[6:0], flags_in.carry};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[7];
         end
         OP_RR: begin
            result               = {8'd0, flags_in.carry, a[7:1]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[0];
         end
         OP_SLA: begin
            result               = {8'd0, a[6:0], 1'b0};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[7];
         end
         OP_SRA: begin
            result               = {8'd0, a[7], a[7:1]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[0];
         end
         OP_SRL: begin
            result               = {8'd0, 1'b0, a[7:1]};
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b0;
            flags_out.carry      = a[0];
         end
         OP_BIT: begin
            result               = {8'd0, a};
            flags_out.zero       = ~|(a & bit_mask);
            flags_out.subtract   = 1'b0;
            flags_out.half_carry = 1'b1;
            set_zero             = 1'b0;
         end
         OP_SET: begin
            result   = {8'd0, a | bit_mask};
            set_zero = 1'b0;
         end
         OP_RES: begin
            result   = {8'd0, a & ~bit_mask};
            set_zero = 1'b0;
         end
         OP_DAA: begin
            if (flags_in.subtract) begin
               result = {8'd0, a - daa_sub};
            end else begin
               result          = {8'd0, a + daa_add};
               flags_out.carry = daa_hi;
            end
            flags_out.half_carry = 1'b0;
         end
         default: begin
            // unused codes pass the operand and flags straight through
            set_zero = 1'b0;
         end
      endcase
      if (set_zero) begin
         flags_out.zero = (result == '0);
      end
   end

endmodule

>>> rtl/cpu8_alu_with_flags_top.sv
// Top level of the 8-bit ALU with flags: input register, datapath, result register.
// Depends on cpu8alu_pkg and cpu8alu_core.
//
//  channel | dir | beat content
//  req_    | in  | tuser: opcode; tdata: operand_a, operand_b, bit_index, Z, N, H, C
//  rsp_    | out | tdata: result, Z, N, H, C
//
// One beat in per cycle, one beat out per cycle at full rate while rsp_tready stays high.
// When a request beat is taken it loads the input register; the result register then loads
// the ALU datapath output once the rsp_ side has room, and rsp_tvalid rises.
// A stalled rsp_ side holds its beat; the input register keeps filling until
// both stages are full, then req_tready drops.
// Synchronous active-high reset empties both stages.

module cpu8_alu_with_flags_top
   import cpu8alu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] operand_a, [31:16] operand_b, [34:32] bit_index, [35] zero_in,
   // [36] subtract_in, [37] half_carry_in, [38] carry_in, [39] zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [4:0] opcode
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] result, [16] zero_out, [17] subtract_out, [18] half_carry_out,
   // [19] carry_out, [23:20] zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [OPCODE_W-1:0]  s1_opcode_ff;
   logic [WORD_W-1:0]    s1_a_ff;
   logic [WORD_W-1:0]    s1_b_ff;
   logic [BIT_IDX_W-1:0] s1_bit_ff;
   flags_type            s1_flags_ff;

   logic                 s2_valid_ff, s2_valid_in;
   logic [WORD_W-1:0]    s2_result_ff;
   flags_type            s2_flags_ff;

   logic                 s2_ready;
   logic                 s1_ready;
   logic                 req_take;
   logic                 s1_move;
   logic [WORD_W-1:0]    alu_result;
   flags_type            alu_flags;
   flags_type            req_flags;

   assign s2_ready = !s2_valid_ff || rsp_tready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_take = req_tvalid && s1_ready;
   assign s1_move  = s1_valid_ff && s2_ready;

   assign req_flags.zero       = req_tdata[35];
   assign req_flags.subtract   = req_tdata[36];
   assign req_flags.half_carry = req_tdata[37];
   assign req_flags.carry      = req_tdata[38];

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_tuser;
         s1_a_ff      <= req_tdata[15:0];
         s1_b_ff      <= req_tdata[31:16];
         s1_bit_ff    <= req_tdata[34:32];
         s1_flags_ff  <= req_flags;
      end
   end

   cpu8alu_core u_core (
      .opcode    (s1_opcode_ff),
      .operand_a (s1_a_ff),
      .operand_b (s1_b_ff),
      .bit_index (s1_bit_ff),
      .flags_in  (s1_flags_ff),
      .result    (alu_result),
      .flags_out (alu_flags)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_result_ff <= alu_result;
         s2_flags_ff  <= alu_flags;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'd0, s2_flags_ff.carry, s2_flags_ff.half_carry,
                        s2_flags_ff.subtract, s2_flags_ff.zero, s2_result_ff};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat lost at input register");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_a_ff) && $stable(s1_opcode_ff))
      else $error("input register changed while blocked");

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_tvalid)
      else $error("beat lost between stages");

endmodule
